/* sv/vtsrp_pkg.sv */
// Package for the VIA timers, shift register and port core: codes, masks and word layout.
package vtsrp_pkg;

  // Item kinds carried on the input word
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register numbers, 6522 numbering
  typedef enum logic [3:0] {
    SEL_ORB  = 4'd0,
    SEL_ORA  = 4'd1,
    SEL_DDRB = 4'd2,
    SEL_DDRA = 4'd3,
    SEL_T1CL = 4'd4,
    SEL_T1CH = 4'd5,
    SEL_T1LL = 4'd6,
    SEL_T1LH = 4'd7,
    SEL_T2CL = 4'd8,
    SEL_T2CH = 4'd9,
    SEL_SR   = 4'd10,
    SEL_ACR  = 4'd11,
    SEL_PCR  = 4'd12,
    SEL_IFR  = 4'd13,
    SEL_IER  = 4'd14,
    SEL_ORAN = 4'd15
  } reg_sel_t;

  // Interrupt flag bits (7-bit flag and enable registers)
  localparam logic [6:0] FLAG_SR = 7'h04;
  localparam logic [6:0] FLAG_T2 = 7'h20;
  localparam logic [6:0] FLAG_T1 = 7'h40;

  // ACR fields
  localparam logic [7:0] ACR_SR_MODE_MASK = 8'h1C;
  localparam logic [7:0] ACR_SR_SHIFT_IN  = 8'h08;
  localparam int unsigned ACR_T1_FREE_BIT = 6;
  localparam int unsigned ACR_T2_PULSE_BIT = 5;

  // Port B bit that drives the card select, active low
  localparam int unsigned PB_CARD_SEL_BIT = 6;

  localparam logic [7:0] SPI_FILL = 8'hFF;
  localparam logic [15:0] TIMER_ROLL = 16'hFFFF;

  // Word widths on the two channels
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 6;
  localparam int unsigned OUT_DATA_W = 24;

  // Fields of one input word
  typedef struct packed {
    op_t      op;
    reg_sel_t reg_sel;
    logic [7:0] write_data;
    logic [7:0] spi_reply;
  } in_item_t;

  // Fields of one result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       spi_start;
    logic [7:0] spi_send;
    logic       card_select;
  } out_item_t;

endpackage

/* sv/via_timers_shift_register_port_core.sv */
// Top level of the VIA timers, shift register and port core.
//
// Input channel in_*: one word is a register read, a register write or one
// clock tick. in_tuser carries the kind and the register number, in_tdata the
// write byte and the card's reply byte for a shift register exchange.
// Result channel out_*: exactly one result word per input word, in order:
// read byte, IRQ line after the word, SPI exchange strobe and sent byte, and
// the card select level.
// Path: an accepted word is held in the input register, processed, and
// loaded into the result register once that register is free, which raises
// out_tvalid. Throughput: one word per cycle while the receiver takes results.
// The register state (port B, ACR, PCR, IER/IFR, shift register, both
// timers) is read and written by one short pass of logic between the input
// register and the result register.
// Reset (rst_n low, synchronous) clears all register state and empties both
// stages; card_select reads 1 after reset since port B bit 6 is 0.
// When the receiver stalls, the result word holds, the input register keeps
// the next word, and in_tready drops once both are full.
module via_timers_shift_register_port_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: [7:0] write_data, [15:8] spi_reply
  input  logic [vtsrp_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: [1:0] op, [5:2] reg_sel
  input  logic [vtsrp_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: [7:0] read_data, [8] irq_line, [9] spi_start,
  //            [17:10] spi_send, [18] card_select, [23:19] zero
  output logic [vtsrp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import vtsrp_pkg::*;

  // Pipeline registers
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_free;
  logic      advance;

  // Block state
  logic [7:0]  port_b_out_r, port_b_out_nxt;
  logic [7:0]  port_b_dir_r, port_b_dir_nxt;
  logic [7:0]  aux_control_r, aux_control_nxt;
  logic [7:0]  periph_control_r, periph_control_nxt;
  logic [6:0]  irq_enable_r, irq_enable_nxt;
  logic [6:0]  irq_flags_r, irq_flags_nxt;
  logic [7:0]  shift_data_r, shift_data_nxt;
  logic [15:0] t1_latch_r, t1_latch_nxt;
  logic [15:0] t1_count_r, t1_count_nxt;
  logic        t1_active_r, t1_active_nxt;
  logic        t1_done_r, t1_done_nxt;
  logic [7:0]  t2_latch_low_r, t2_latch_low_nxt;
  logic [15:0] t2_count_r, t2_count_nxt;
  logic        t2_active_r, t2_active_nxt;
  logic        t2_done_r, t2_done_nxt;

  logic shift_in_mode;

  // Handshake: the result register frees when empty or being taken
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.op         <= op_t'(in_tuser[1:0]);
      in_item_r.reg_sel    <= reg_sel_t'(in_tuser[5:2]);
      in_item_r.write_data <= in_tdata[7:0];
      in_item_r.spi_reply  <= in_tdata[15:8];
    end
  end

  assign shift_in_mode = (aux_control_r & ACR_SR_MODE_MASK) == ACR_SR_SHIFT_IN;

  // Process one word against the register state
  always_comb begin
    port_b_out_nxt     = port_b_out_r;
    port_b_dir_nxt     = port_b_dir_r;
    aux_control_nxt    = aux_control_r;
    periph_control_nxt = periph_control_r;
    irq_enable_nxt     = irq_enable_r;
    irq_flags_nxt      = irq_flags_r;
    shift_data_nxt     = shift_data_r;
    t1_latch_nxt       = t1_latch_r;
    t1_count_nxt       = t1_count_r;
    t1_active_nxt      = t1_active_r;
    t1_done_nxt        = t1_done_r;
    t2_latch_low_nxt   = t2_latch_low_r;
    t2_count_nxt       = t2_count_r;
    t2_active_nxt      = t2_active_r;
    t2_done_nxt        = t2_done_r;
    out_item_nxt       = '0;

    case (in_item_r.op)
      OP_READ: begin
        case (in_item_r.reg_sel)
          SEL_ORB:  out_item_nxt.read_data = port_b_out_r;
          SEL_DDRB: out_item_nxt.read_data = port_b_dir_r;
          SEL_ACR:  out_item_nxt.read_data = aux_control_r;
          SEL_PCR:  out_item_nxt.read_data = periph_control_r;
          SEL_IER:  out_item_nxt.read_data = {1'b1, irq_enable_r};
          SEL_IFR: begin
            out_item_nxt.read_data = {|(irq_flags_r & irq_enable_r),
                                      irq_flags_r | (shift_in_mode ? FLAG_SR : 7'h00)};
          end
          SEL_SR: begin
            // Shift-in mode pulls one byte from the card on a read
            if (shift_in_mode) begin
              out_item_nxt.spi_start = 1'b1;
              out_item_nxt.spi_send  = SPI_FILL;
              shift_data_nxt         = in_item_r.spi_reply;
            end
            irq_flags_nxt          = irq_flags_r & ~FLAG_SR;
            out_item_nxt.read_data = shift_in_mode ? in_item_r.spi_reply : shift_data_r;
          end
          SEL_T1CL: begin
            irq_flags_nxt          = irq_flags_r & ~FLAG_T1;
            out_item_nxt.read_data = t1_count_r[7:0];
          end
          SEL_T1CH: out_item_nxt.read_data = t1_count_r[15:8];
          SEL_T1LL: out_item_nxt.read_data = t1_latch_r[7:0];
          SEL_T1LH: out_item_nxt.read_data = t1_latch_r[15:8];
          SEL_T2CL: begin
            irq_flags_nxt          = irq_flags_r & ~FLAG_T2;
            out_item_nxt.read_data = t2_count_r[7:0];
          end
          SEL_T2CH: out_item_nxt.read_data = t2_count_r[15:8];
          default:  out_item_nxt.read_data = 8'h00;
        endcase
      end
      OP_WRITE: begin
        case (in_item_r.reg_sel)
          SEL_ORB:  port_b_out_nxt     = in_item_r.write_data;
          SEL_DDRB: port_b_dir_nxt     = in_item_r.write_data;
          SEL_ACR:  aux_control_nxt    = in_item_r.write_data;
          SEL_PCR:  periph_control_nxt = in_item_r.write_data;
          SEL_IER: begin
            // Bit 7 picks set or clear for the named enables
            if (in_item_r.write_data[7]) begin
              irq_enable_nxt = irq_enable_r | in_item_r.write_data[6:0];
            end else begin
              irq_enable_nxt = irq_enable_r & ~in_item_r.write_data[6:0];
            end
          end
          SEL_IFR: irq_flags_nxt = irq_flags_r & ~in_item_r.write_data[6:0];
          SEL_SR: begin
            out_item_nxt.spi_start = 1'b1;
            out_item_nxt.spi_send  = in_item_r.write_data;
            shift_data_nxt         = in_item_r.spi_reply;
            irq_flags_nxt          = irq_flags_r | FLAG_SR;
          end
          SEL_T1CL, SEL_T1LL: t1_latch_nxt = {t1_latch_r[15:8], in_item_r.write_data};
          SEL_T1CH: begin
            t1_latch_nxt  = {in_item_r.write_data, t1_latch_r[7:0]};
            t1_count_nxt  = {in_item_r.write_data, t1_latch_r[7:0]};
            t1_active_nxt = 1'b1;
            t1_done_nxt   = 1'b0;
            irq_flags_nxt = irq_flags_r & ~FLAG_T1;
          end
          SEL_T1LH: begin
            t1_latch_nxt  = {in_item_r.write_data, t1_latch_r[7:0]};
            irq_flags_nxt = irq_flags_r & ~FLAG_T1;
          end
          SEL_T2CL: t2_latch_low_nxt = in_item_r.write_data;
          SEL_T2CH: begin
            t2_count_nxt  = {in_item_r.write_data, t2_latch_low_r};
            t2_active_nxt = 1'b1;
            t2_done_nxt   = 1'b0;
            irq_flags_nxt = irq_flags_r & ~FLAG_T2;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // Timer 1: reload in free-run, flag once and roll over in one-shot
        if (t1_active_r) begin
          if (t1_count_r == 16'h0000) begin
            if (aux_control_r[ACR_T1_FREE_BIT]) begin
              irq_flags_nxt = irq_flags_nxt | FLAG_T1;
              t1_count_nxt  = t1_latch_r;
            end else begin
              if (!t1_done_r) begin
                irq_flags_nxt = irq_flags_nxt | FLAG_T1;
                t1_done_nxt   = 1'b1;
              end
              t1_count_nxt = TIMER_ROLL;
            end
          end else begin
            t1_count_nxt = t1_count_r - 16'd1;
          end
        end
        // Timer 2: one-shot, halted in pulse-count mode
        if (t2_active_r && !aux_control_r[ACR_T2_PULSE_BIT]) begin
          if (t2_count_r == 16'h0000) begin
            if (!t2_done_r) begin
              irq_flags_nxt = irq_flags_nxt | FLAG_T2;
              t2_done_nxt   = 1'b1;
            end
            t2_count_nxt = TIMER_ROLL;
          end else begin
            t2_count_nxt = t2_count_r - 16'd1;
          end
        end
      end
      default: ;
    endcase

    out_item_nxt.irq_line    = |(irq_flags_nxt & irq_enable_nxt);
    out_item_nxt.card_select = !port_b_out_nxt[PB_CARD_SEL_BIT];
  end

  // Commit state when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_b_out_r     <= '0;
      port_b_dir_r     <= '0;
      aux_control_r    <= '0;
      periph_control_r <= '0;
      irq_enable_r     <= '0;
      irq_flags_r      <= '0;
      shift_data_r     <= '0;
      t1_latch_r       <= '0;
      t1_count_r       <= '0;
      t1_active_r      <= 1'b0;
      t1_done_r        <= 1'b0;
      t2_latch_low_r   <= '0;
      t2_count_r       <= '0;
      t2_active_r      <= 1'b0;
      t2_done_r        <= 1'b0;
    end else if (advance) begin
      port_b_out_r     <= port_b_out_nxt;
      port_b_dir_r     <= port_b_dir_nxt;
      aux_control_r    <= aux_control_nxt;
      periph_control_r <= periph_control_nxt;
      irq_enable_r     <= irq_enable_nxt;
      irq_flags_r      <= irq_flags_nxt;
      shift_data_r     <= shift_data_nxt;
      t1_latch_r       <= t1_latch_nxt;
      t1_count_r       <= t1_count_nxt;
      t1_active_r      <= t1_active_nxt;
      t1_done_r        <= t1_done_nxt;
      t2_latch_low_r   <= t2_latch_low_nxt;
      t2_count_r       <= t2_count_nxt;
      t2_active_r      <= t2_active_nxt;
      t2_done_r        <= t2_done_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b00000,
                       out_item_r.card_select,
                       out_item_r.spi_send,
                       out_item_r.spi_start,
                       out_item_r.irq_line,
                       out_item_r.read_data};

endmodule

/* sv/vtsrp_checker.sv */
// Port checker for the VIA timers, shift register and port core, with its bind.
module vtsrp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vtsrp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import vtsrp_pkg::*;

  // Stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // No byte is sent unless an exchange happened
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> out_tdata[17:10] == 8'h00)
    else $error("spi_send nonzero without spi_start");

  // A fresh result traces back to a word accepted earlier on the input channel
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without an accepted word");

  // Reset empties the result register
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind via_timers_shift_register_port_core vtsrp_checker u_vtsrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
